// ===== rtl/sp2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sp2rgb_pkg
// Shared widths, register indexes and format codes of the scan pixel
// to RGB888 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sp2rgb_pkg;

  localparam int MAX_LINE_PIXELS = 16384;

  localparam int BYTE_W    = 8;
  localparam int FMT_W     = 3;
  localparam int PPL_W     = 15;
  localparam int BPL_W     = 17;
  localparam int LANES     = 8;
  localparam int LANE_W    = 3;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // source_format codes
  localparam logic [FMT_W-1:0] FMT_MONO   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_GRAY8  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_GRAY16 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGB16  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_RGB8   = 3'd4;

  // register indexes (byte address 4*index)
  localparam logic [1:0] REG_SOURCE_FORMAT    = 2'd0;
  localparam logic [1:0] REG_PIXELS_PER_LINE  = 2'd1;
  localparam logic [1:0] REG_BYTES_PER_LINE   = 2'd2;
  localparam logic [1:0] REG_HIGH_BYTE_OFFSET = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// ===== rtl/sp2rgb_if.sv =====
// ----------------------------------------------------------------------------
// sp2rgb_if
// Valid/ready channels of the converter: source bytes in, pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sp2rgb_byte_if;
  logic                            valid;
  logic                            ready;
  logic [sp2rgb_pkg::BYTE_W-1:0]   data_byte;
  logic                            frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface sp2rgb_pix_if;
  logic                            valid;
  logic                            ready;
  logic [sp2rgb_pkg::BYTE_W-1:0]   red;
  logic [sp2rgb_pkg::BYTE_W-1:0]   green;
  logic [sp2rgb_pkg::BYTE_W-1:0]   blue;
  logic                            line_end;
  logic                            last_of_run;

  modport source (output valid, red, green, blue, line_end, last_of_run, input ready);
  modport sink   (input valid, red, green, blue, line_end, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/scan_pixel_to_rgb888_converter_core.sv =====
// ----------------------------------------------------------------------------
// scan_pixel_to_rgb888_converter_core
// Converts raw scanner bytes (mono1, gray8, gray16, rgb16, rgb8) to RGB888.
// ----------------------------------------------------------------------------
// A byte beat is decoded in the cycle it is accepted: line position and held
// channels advance at once and the pixels it yields are latched into a lane
// register (up to eight lanes for 1-bit mono, one lane otherwise). A single
// result register drains the lanes one pixel per cycle while the pixel side
// is ready; gray, 16-bit and rgb8 formats then run at one byte per cycle, while
// a mono byte holds off the next one until its lanes have drained.
// The next byte is taken in the same cycle the last lane moves to the
// result register; a byte's first pixel passes through the lane register and
// then the result register. Configure only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_pixel_to_rgb888_converter_core #(
  parameter int MAX_LINE_PIXELS = sp2rgb_pkg::MAX_LINE_PIXELS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  sp2rgb_byte_if.sink                       byte_i,
  sp2rgb_pix_if.source                      pix_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [sp2rgb_pkg::APB_AW-1:0]     paddr,
  input  wire  [sp2rgb_pkg::APB_DW-1:0]     pwdata,
  output logic [sp2rgb_pkg::APB_DW-1:0]     prdata,
  output logic                              pready
);

  localparam int WW    = $clog2(MAX_LINE_PIXELS + 1);
  localparam int XW    = ((WW > sp2rgb_pkg::BPL_W + sp2rgb_pkg::LANE_W) ?
                          WW : (sp2rgb_pkg::BPL_W + sp2rgb_pkg::LANE_W)) + 1;
  localparam int BPL_W = sp2rgb_pkg::BPL_W;
  localparam int LANES = sp2rgb_pkg::LANES;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [sp2rgb_pkg::FMT_W-1:0] fmt_q;
  logic [sp2rgb_pkg::PPL_W-1:0] ppl_q;
  logic [BPL_W-1:0]             bpl_q;
  logic                         hbo_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= sp2rgb_pkg::FMT_GRAY8;
      ppl_q <= sp2rgb_pkg::PPL_W'(1);
      bpl_q <= BPL_W'(1);
      hbo_q <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sp2rgb_pkg::REG_SOURCE_FORMAT:    fmt_q <= pwdata[sp2rgb_pkg::FMT_W-1:0];
        sp2rgb_pkg::REG_PIXELS_PER_LINE:  ppl_q <= pwdata[sp2rgb_pkg::PPL_W-1:0];
        sp2rgb_pkg::REG_BYTES_PER_LINE:   bpl_q <= pwdata[BPL_W-1:0];
        sp2rgb_pkg::REG_HIGH_BYTE_OFFSET: hbo_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sp2rgb_pkg::REG_SOURCE_FORMAT:
        prdata = sp2rgb_pkg::APB_DW'(fmt_q);
      sp2rgb_pkg::REG_PIXELS_PER_LINE:
        prdata = sp2rgb_pkg::APB_DW'(ppl_q);
      sp2rgb_pkg::REG_BYTES_PER_LINE:
        prdata = sp2rgb_pkg::APB_DW'(bpl_q);
      sp2rgb_pkg::REG_HIGH_BYTE_OFFSET:
        prdata = sp2rgb_pkg::APB_DW'(hbo_q);
      default:
        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Line position state. Mod/div counters by 3 and 6 follow byte_pos_q
  // so rgb formats need no divider.
  // --------------------------------------------------------------------------
  logic [BPL_W-1:0]            byte_pos_q, byte_pos_d;
  logic [2:0]                  mod6_q, mod6_d;
  logic [BPL_W-1:0]            div6_q, div6_d;
  logic [1:0]                  mod3_q, mod3_d;
  logic [BPL_W-1:0]            div3_q, div3_d;
  logic [sp2rgb_pkg::BYTE_W-1:0] held_red_q, held_red_d;
  logic [sp2rgb_pkg::BYTE_W-1:0] held_green_q, held_green_d;

  // Lane register and result register
  logic [LANES-1:0]              pend_q, pend_d;
  logic [LANES-1:0]              le_q, le_d;
  logic                          mono_q, mono_d;
  logic [sp2rgb_pkg::BYTE_W-1:0] data_q, data_d;
  sp2rgb_pkg::rgb_t              pix_q, pix_d;

  logic                          out_valid_q;
  sp2rgb_pkg::rgb_t              out_pix_q;
  logic                          out_le_q;
  logic                          out_last_q;

  logic                          accept;
  logic                          advance;
  logic [LANES-1:0]              pick;
  logic [LANES-1:0]              rest;
  logic [sp2rgb_pkg::LANE_W-1:0] pick_idx;

  // effective (post frame_start) state
  logic [BPL_W-1:0]              b;
  logic [2:0]                    m6;
  logic [BPL_W-1:0]              x6;
  logic [1:0]                    m3;
  logic [BPL_W-1:0]              x3;
  logic [sp2rgb_pkg::BYTE_W-1:0] hr;
  logic [sp2rgb_pkg::BYTE_W-1:0] hg;
  logic [sp2rgb_pkg::BYTE_W-1:0] d;
  logic [XW-1:0]                 width;
  logic [XW-1:0]                 xs;
  logic                          wrap;
  logic                          one_hit;
  logic [XW-1:0]                 xm;

  assign d = byte_i.data_byte;

  always_comb begin
    if (ppl_q > MAX_LINE_PIXELS) width = XW'(MAX_LINE_PIXELS);
    else                         width = XW'(ppl_q);
  end

  always_comb begin
    b  = byte_pos_q;
    m6 = mod6_q;
    x6 = div6_q;
    m3 = mod3_q;
    x3 = div3_q;
    hr = held_red_q;
    hg = held_green_q;
    if (byte_i.frame_start) begin
      b  = '0;
      m6 = '0;
      x6 = '0;
      m3 = '0;
      x3 = '0;
      hr = '0;
      hg = '0;
    end
  end

  // Decode the incoming byte into lanes and the next line position.
  always_comb begin
    held_red_d   = hr;
    held_green_d = hg;
    pend_d       = '0;
    le_d         = '0;
    mono_d       = 1'b0;
    data_d       = d;
    pix_d        = '{red: d, green: d, blue: d};
    one_hit      = 1'b0;
    xs           = '0;
    xm           = '0;

    case (fmt_q)
      sp2rgb_pkg::FMT_MONO: begin
        mono_d = 1'b1;
        for (int i = 0; i < LANES; i++) begin
          xm        = XW'({b, sp2rgb_pkg::LANE_W'(i)});
          pend_d[i] = (xm < width);
          le_d[i]   = ((xm + XW'(1)) == width);
        end
      end
      sp2rgb_pkg::FMT_GRAY8: begin
        xs      = XW'(b);
        one_hit = 1'b1;
      end
      sp2rgb_pkg::FMT_GRAY16: begin
        xs      = XW'(b[BPL_W-1:1]);
        one_hit = (b[0] == hbo_q);
      end
      sp2rgb_pkg::FMT_RGB16: begin
        xs = XW'(x6);
        if (m6 == {2'b00, hbo_q})       held_red_d   = d;
        else if (m6 == {2'b01, hbo_q})  held_green_d = d;
        else if (m6 == {2'b10, hbo_q}) begin
          one_hit = 1'b1;
          pix_d   = '{red: hr, green: hg, blue: d};
        end
      end
      sp2rgb_pkg::FMT_RGB8: begin
        xs = XW'(x3);
        if (m3 == 2'd0)      held_red_d   = d;
        else if (m3 == 2'd1) held_green_d = d;
        else begin
          one_hit = 1'b1;
          pix_d   = '{red: hr, green: hg, blue: d};
        end
      end
      default: ;
    endcase

    if (one_hit && (xs < width)) begin
      pend_d[0] = 1'b1;
      le_d[0]   = ((xs + XW'(1)) == width);
    end

    wrap = ((BPL_W + 1)'(b) + (BPL_W + 1)'(1)) >= (BPL_W + 1)'(bpl_q);
    if (wrap) begin
      byte_pos_d = '0;
      mod6_d     = '0;
      div6_d     = '0;
      mod3_d     = '0;
      div3_d     = '0;
    end else begin
      byte_pos_d = b + BPL_W'(1);
      if (m6 == 3'd5) begin
        mod6_d = '0;
        div6_d = x6 + BPL_W'(1);
      end else begin
        mod6_d = m6 + 3'd1;
        div6_d = x6;
      end
      if (m3 == 2'd2) begin
        mod3_d = '0;
        div3_d = x3 + BPL_W'(1);
      end else begin
        mod3_d = m3 + 2'd1;
        div3_d = x3;
      end
    end
  end

  // Lowest pending lane goes out first (mono MSB first).
  always_comb begin
    pick     = '0;
    pick_idx = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        pick     = '0;
        pick[i]  = 1'b1;
        pick_idx = sp2rgb_pkg::LANE_W'(i);
      end
    end
    rest = pend_q & ~pick;
  end

  assign advance      = (|pend_q) && (!out_valid_q || pix_o.ready);
  assign byte_i.ready = (pend_q == '0) || (advance && (rest == '0));
  assign accept       = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      mod6_q       <= '0;
      div6_q       <= '0;
      mod3_q       <= '0;
      div3_q       <= '0;
      held_red_q   <= '0;
      held_green_q <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        byte_pos_q   <= byte_pos_d;
        mod6_q       <= mod6_d;
        div6_q       <= div6_d;
        mod3_q       <= mod3_d;
        div3_q       <= div3_d;
        held_red_q   <= held_red_d;
        held_green_q <= held_green_d;
        pend_q       <= pend_d;
      end else if (advance) begin
        pend_q <= rest;
      end
      if (advance)           out_valid_q <= 1'b1;
      else if (pix_o.ready)  out_valid_q <= 1'b0;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      le_q   <= le_d;
      mono_q <= mono_d;
      data_q <= data_d;
      pix_q  <= pix_d;
    end
    if (advance) begin
      if (mono_q) begin
        out_pix_q <= data_q[sp2rgb_pkg::LANE_W'(LANES - 1) - pick_idx] ?
                     {3{8'h00}} : {3{8'hFF}};
      end else begin
        out_pix_q <= pix_q;
      end
      out_le_q   <= |(le_q & pick);
      out_last_q <= (rest == '0);
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.red         = out_pix_q.red;
  assign pix_o.green       = out_pix_q.green;
  assign pix_o.blue        = out_pix_q.blue;
  assign pix_o.line_end    = out_le_q;
  assign pix_o.last_of_run = out_last_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw scanner bytes into the RGB888 converter under random
// back-pressure and register settings, predicts every pixel in step with
// the accepted bytes and checks each pixel beat against that prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [sp2rgb_pkg::FMT_W-1:0] FMT_RESERVED = 3'd7;
  localparam int IDLE_SETTLE = 16;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int RANDOM_ITEMS = 180;

  typedef struct packed {
    sp2rgb_pkg::rgb_t color;
    logic line_end;
    logic last_of_run;
  } pixel_t;

  // Tracks line position and held channels; queues the pixels each byte yields.
  class rgb_expander;
    logic [sp2rgb_pkg::FMT_W-1:0]  fmt;
    logic [sp2rgb_pkg::PPL_W-1:0]  ppl;
    logic [sp2rgb_pkg::BPL_W-1:0]  bpl;
    logic                          hbo;
    logic [sp2rgb_pkg::BPL_W-1:0]  byte_pos;
    logic [sp2rgb_pkg::PPL_W-1:0]  pix_col;
    logic [7:0]                    held_red;
    logic [7:0]                    held_green;
    pixel_t                        pending_pixels[$];
    int                            errors;

    function new();
      fmt = sp2rgb_pkg::FMT_GRAY8;
      ppl = 1;
      bpl = 1;
      hbo = 1'b1;
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      byte_pos = '0;
      pix_col = '0;
      held_red = '0;
      held_green = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        sp2rgb_pkg::REG_SOURCE_FORMAT:    fmt = value[sp2rgb_pkg::FMT_W-1:0];
        sp2rgb_pkg::REG_PIXELS_PER_LINE:  ppl = value[sp2rgb_pkg::PPL_W-1:0];
        sp2rgb_pkg::REG_BYTES_PER_LINE:   bpl = value[sp2rgb_pkg::BPL_W-1:0];
        sp2rgb_pkg::REG_HIGH_BYTE_OFFSET: hbo = value[0];
        default: ;
      endcase
    endfunction

    function void emit(int x, int width, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t px;
      px.color.red = r;
      px.color.green = g;
      px.color.blue = b;
      px.line_end = (x + 1 == width);
      px.last_of_run = 1'b0;
      pending_pixels.push_back(px);
      pix_col = sp2rgb_pkg::PPL_W'(x + 1);
    endfunction

    function void take_byte(logic [7:0] d, logic frame_start);
      int b, width, x, m, i, first;
      logic [7:0] v;
      if (frame_start) clear_line();
      b = byte_pos;
      width = (ppl > sp2rgb_pkg::MAX_LINE_PIXELS) ? sp2rgb_pkg::MAX_LINE_PIXELS : ppl;
      first = pending_pixels.size();
      case (fmt)
        sp2rgb_pkg::FMT_MONO: begin
          for (i = 0; i < 8; i++) begin
            x = 8 * b + i;
            // set bit is black, clear bit is white
            v = d[7 - i] ? 8'd0 : 8'd255;
            if (x < width) emit(x, width, v, v, v);
          end
        end
        sp2rgb_pkg::FMT_GRAY8: begin
          if (b < width) emit(b, width, d, d, d);
        end
        sp2rgb_pkg::FMT_GRAY16: begin
          x = b / 2;
          if ((b % 2) == hbo && x < width) emit(x, width, d, d, d);
        end
        sp2rgb_pkg::FMT_RGB16: begin
          m = b % 6;
          x = b / 6;
          if (m == hbo) held_red = d;
          else if (m == 2 + hbo) held_green = d;
          else if (m == 4 + hbo && x < width) emit(x, width, held_red, held_green, d);
        end
        sp2rgb_pkg::FMT_RGB8: begin
          m = b % 3;
          x = b / 3;
          if (m == 0) held_red = d;
          else if (m == 1) held_green = d;
          else if (x < width) emit(x, width, held_red, held_green, d);
        end
        default: ;
      endcase
      if (pending_pixels.size() > first)
        pending_pixels[pending_pixels.size() - 1].last_of_run = 1'b1;
      if (b + 1 >= bpl) begin
        byte_pos = '0;
        pix_col = '0;
      end else begin
        byte_pos = sp2rgb_pkg::BPL_W'(b + 1);
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel beat with nothing pending: r=%0d g=%0d b=%0d",
               got.color.red, got.color.green, got.color.blue);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      check_field("red", want.color.red, got.color.red);
      check_field("green", want.color.green, got.color.green);
      check_field("blue", want.color.blue, got.color.blue);
      check_field("line_end", 8'(want.line_end), 8'(got.line_end));
      check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sp2rgb_pkg::APB_AW-1:0] paddr;
  logic [sp2rgb_pkg::APB_DW-1:0] pwdata;
  logic [sp2rgb_pkg::APB_DW-1:0] prdata;
  logic pready;

  int tx_max = 8;
  int rx_max = 8;
  int rx_hold = 0;
  int random_sent;

  rgb_expander conv = new();

  sp2rgb_byte_if byte_bus ();
  sp2rgb_pix_if  pix_bus ();

  scan_pixel_to_rgb888_converter_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_bus),
    .pix_o   (pix_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Note accepted bytes before checking pixels; a pixel never follows its byte
  // in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_bus.valid && byte_bus.ready)
        conv.take_byte(byte_bus.data_byte, byte_bus.frame_start);
      if (pix_bus.valid && pix_bus.ready)
        conv.check_pixel({pix_bus.red, pix_bus.green, pix_bus.blue,
                          pix_bus.line_end, pix_bus.last_of_run});
    end
  end

  initial begin : pixel_sink
    int stall;
    pix_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (rx_hold > 0) ? rx_hold : $urandom_range(0, rx_max);
      rx_hold = 0;
      repeat (stall) begin
        @(negedge clk_i);
        pix_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      pix_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!pix_bus.valid);
    end
  end

  task automatic send_byte(logic [7:0] data, logic frame_start);
    int gap;
    gap = $urandom_range(0, tx_max);
    repeat (gap) begin
      @(negedge clk_i);
      byte_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    byte_bus.valid <= 1'b1;
    byte_bus.data_byte <= data;
    byte_bus.frame_start <= frame_start;
    do @(posedge clk_i); while (!byte_bus.ready);
  endtask

  task automatic send_line(int count);
    int i;
    for (i = 0; i < count; i++) send_byte(8'($urandom()), i == 0);
  endtask

  // Drop valid, then hold until every pending pixel has come out.
  task automatic wait_idle();
    @(negedge clk_i);
    byte_bus.valid <= 1'b0;
    while (conv.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    conv.write_reg(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(logic [sp2rgb_pkg::FMT_W-1:0] fmt, int ppl, int bpl, logic hbo);
    wait_idle();
    reg_write(sp2rgb_pkg::REG_SOURCE_FORMAT, 32'(fmt));
    reg_write(sp2rgb_pkg::REG_PIXELS_PER_LINE, 32'(ppl));
    reg_write(sp2rgb_pkg::REG_BYTES_PER_LINE, 32'(bpl));
    reg_write(sp2rgb_pkg::REG_HIGH_BYTE_OFFSET, 32'(hbo));
  endtask

  task automatic random_phase(output int sent);
    logic [sp2rgb_pkg::FMT_W-1:0] fmt;
    logic hbo;
    int ppl, bpl, need, count, style, i;
    style = $urandom_range(0, 9);
    if ($urandom_range(0, 9) == 0)
      fmt = sp2rgb_pkg::FMT_RGB8 + sp2rgb_pkg::FMT_W'($urandom_range(1, 3));
    else fmt = sp2rgb_pkg::FMT_W'($urandom_range(0, 4));
    hbo = 1'($urandom_range(0, 1));
    ppl = $urandom_range(0, 12);
    case (fmt)
      sp2rgb_pkg::FMT_MONO:   need = (ppl + 7) / 8;
      sp2rgb_pkg::FMT_GRAY8:  need = ppl;
      sp2rgb_pkg::FMT_GRAY16: need = 2 * ppl;
      sp2rgb_pkg::FMT_RGB16:  need = 6 * ppl;
      sp2rgb_pkg::FMT_RGB8:   need = 3 * ppl;
      default:                need = ppl;
    endcase
    if (style < 2) begin
      ppl = $urandom_range(0, 32767);
      bpl = $urandom_range(0, 131071);
    end else if (style == 2) begin
      // line no longer than its pixels need, often too short
      bpl = $urandom_range(0, need);
    end else begin
      bpl = need + $urandom_range(0, 3);
    end
    tx_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    rx_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    configure(fmt, ppl, bpl, hbo);
    count = $urandom_range(15, 45);
    for (i = 0; i < count; i++)
      send_byte(8'($urandom()), (i == 0) ? 1'($urandom_range(0, 1))
                                         : ($urandom_range(0, 23) == 0));
    sent = count;
  endtask

  initial begin : stimulus
    int chunk;
    rst_ni = 1'b0;
    byte_bus.valid = 1'b0;
    byte_bus.data_byte = '0;
    byte_bus.frame_start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: gray8, one pixel per one-byte line.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);

    configure(sp2rgb_pkg::FMT_MONO, 10, 2, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFF, 1'b0);

    configure(sp2rgb_pkg::FMT_GRAY16, 2, 5, 1'b1);
    send_line(5);
    configure(sp2rgb_pkg::FMT_RGB16, 1, 7, 1'b0);
    send_line(7);
    configure(sp2rgb_pkg::FMT_RGB8, 1, 4, 1'b0);
    send_line(4);
    // zero pixels per line: nothing comes out
    configure(sp2rgb_pkg::FMT_GRAY8, 0, 3, 1'b0);
    send_line(1);
    // zero bytes per line: every byte starts a fresh line
    configure(sp2rgb_pkg::FMT_GRAY8, 3, 0, 1'b0);
    send_line(2);

    // Hold the pixel side off while mono bytes keep coming, so the block backs up.
    configure(sp2rgb_pkg::FMT_MONO, 160, 25, 1'b0);
    tx_max = 0;
    rx_hold = 150;
    send_line(20);

    // Advance part way into a line with an undefined format, then switch to
    // mono mid-line; bits past the line width yield nothing.
    configure(FMT_RESERVED, 40, 8, 1'b1);
    rx_max = 0;
    send_line(3);
    wait_idle();
    reg_write(sp2rgb_pkg::REG_SOURCE_FORMAT, 32'(sp2rgb_pkg::FMT_MONO));
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      random_phase(chunk);
      random_sent += chunk;
    end

    wait_idle();
    if (conv.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== scan_pixel_to_rgb888_converter_core.f =====
rtl/sp2rgb_pkg.sv
rtl/sp2rgb_if.sv
rtl/scan_pixel_to_rgb888_converter_core.sv
sim/testbench.sv
